// ===== hdl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, constants and codes for the task scheduler policy unit.
// ----------------------------------------------------------------------------
package tsp_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int ID_W       = 8;
   localparam int RT_W       = 16;
   localparam int TICK_W     = 24;
   localparam int TICK_IDX_W = $clog2(TICK_W);
   localparam int POL_W      = 2;
   localparam int QUANT_W    = 4;

   // fewest held tasks for which reordering or rotation happens
   localparam int MIN_REORDER = 2;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((ID_W + RT_W + 7) / 8) * 8;

   // config port
   localparam int CSR_W     = (POL_W > QUANT_W) ? POL_W : QUANT_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 1'd1;

   // policy codes
   localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
   localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
   localparam logic [POL_W-1:0] POL_SRTF = 2'd2;
   localparam logic [POL_W-1:0] POL_RR   = 2'd3;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 4'd1;

   // command codes
   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // one queue slot
   typedef struct packed {
      logic [TICK_W-1:0] arrival;
      logic [RT_W-1:0]   progress;
      logic [RT_W-1:0]   runtime;
      logic [ID_W-1:0]   task_id;
   } slot_type;

   // result beat, last field in the lowest bits
   typedef struct packed {
      logic [CNT_W-1:0]  queue_count;
      logic [TICK_W-1:0] turnaround;
      logic [TICK_W-1:0] done_time;
      logic              done_res;
      logic [ID_W-1:0]   ran_id;
      logic              ran_valid;
      logic              accepted;
   } rsp_type;

   localparam int RSP_FIELD_W = $bits(rsp_type);
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // queue storage operations
   typedef enum logic [1:0] {
      Q_NONE,
      Q_WR,
      Q_SHIFT,
      Q_SHIFT_WR
   } qop_type;

   typedef struct packed {
      qop_type          op;
      logic [IDX_W-1:0] idx;
      slot_type         data;
   } qctl_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_SORT,
      ST_MOD,
      ST_ROT,
      ST_RUN,
      ST_REPLY
   } state_type;

endpackage

// ===== hdl/task_scheduler_policy_unit.sv =====
// ----------------------------------------------------------------------------
// task_scheduler_policy_unit
// Ready-queue CPU scheduler: FIFO, shortest job, shortest remaining, round robin.
// ----------------------------------------------------------------------------
// Each request beat is either a task arrival or one scheduler tick, and each
// gives exactly one response beat. An arrival goes from accept to reply. A
// tick runs plan, reorder work, run and reply: under shortest job or shortest
// remaining first the queue is bubble sorted by one comparator, pass by pass
// until a pass makes no exchange (a queue already in order costs one pass);
// under round robin a bit-serial remainder of the tick count by the quantum
// decides the rotation, done in a rotate state. Reordering needs two or more
// held tasks. req_tready is high only while the sequencer is idle; a finished
// response waits in the output register, so the next request can be taken
// while it is still pending. The queue holds 16 tasks; a full queue drops
// arrivals with accepted low. Policy and quantum are written through the csr
// port, by the user only while the block is idle; the block does not enforce
// it. A quantum of zero acts as one.
// ----------------------------------------------------------------------------
module task_scheduler_policy_unit (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tsp_pkg::REQ_DATA_W-1:0]   req_tdata,   // task_id, runtime
   input  logic                             req_tuser,   // command

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted, ran_valid, ran_id, done_res, done_time, turnaround, queue_count
   output logic [tsp_pkg::RSP_DATA_W-1:0]   rsp_tdata,

   input  logic                             csr_we,
   input  logic [tsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tsp_pkg::CSR_W-1:0]        csr_wdata
);
   import tsp_pkg::*;

   logic [POL_W-1:0]   policy_ff, policy_in;
   logic [QUANT_W-1:0] quantum_ff, quantum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               ctrl_ready;
   logic               rsp_free;
   logic               rsp_load;
   rsp_type            rsp_next;
   qctl_type           qctl;
   slot_type           head;

   // request beat taken
   assign req_tready = ctrl_ready;
   assign req_accept = req_tvalid & ctrl_ready;

   // config registers
   always_comb begin
      policy_in  = policy_ff;
      quantum_in = quantum_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:  policy_in  = csr_wdata[POL_W-1:0];
            CSR_QUANTUM: quantum_in = csr_wdata[QUANT_W-1:0];
            default:     policy_in  = policy_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= POL_FIFO;
         quantum_ff <= QUANTUM_RESET;
      end else begin
         policy_ff  <= policy_in;
         quantum_ff <= quantum_in;
      end
   end

   // output register: free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   tsp_queue u_queue (
      .clock (clock),
      .qctl  (qctl),
      .head  (head)
   );

   tsp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_cmd     (req_tuser),
      .req_task_id (req_tdata[ID_W-1:0]),
      .req_runtime (req_tdata[ID_W +: RT_W]),
      .policy      (policy_ff),
      .quantum     (quantum_ff),
      .head        (head),
      .rsp_free    (rsp_free),
      .ready       (ctrl_ready),
      .qctl        (qctl),
      .rsp_load    (rsp_load),
      .rsp         (rsp_next)
   );

endmodule

// ===== hdl/tsp_queue.sv =====
// ----------------------------------------------------------------------------
// tsp_queue
// Ready-queue slot storage. Slot 0 is the head; slots shift toward the head.
// ----------------------------------------------------------------------------
module tsp_queue (
   input  logic               clock,
   input  tsp_pkg::qctl_type  qctl,
   output tsp_pkg::slot_type  head
);
   import tsp_pkg::*;

   slot_type slot_ff [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      // last slot has nothing behind it; it keeps its value on a shift
      localparam int NXT = (i < QUEUE_DEPTH - 1) ? i + 1 : i;
      logic hit;

      assign hit = (qctl.idx == IDX_W'(i));

      always_ff @(posedge clock) begin
         unique case (qctl.op)
            Q_NONE: begin
               slot_ff[i] <= slot_ff[i];
            end
            Q_WR: begin
               if (hit) begin
                  slot_ff[i] <= qctl.data;
               end
            end
            Q_SHIFT: begin
               slot_ff[i] <= slot_ff[NXT];
            end
            Q_SHIFT_WR: begin
               slot_ff[i] <= hit ? qctl.data : slot_ff[NXT];
            end
            default: begin
               slot_ff[i] <= slot_ff[i];
            end
         endcase
      end
   end

   assign head = slot_ff[0];

endmodule

// ===== hdl/tsp_keycmp.sv =====
// ----------------------------------------------------------------------------
// tsp_keycmp
// Shared sort-key comparator: total runtime, or remaining time.
// ----------------------------------------------------------------------------
module tsp_keycmp (
   input  tsp_pkg::slot_type  a,
   input  tsp_pkg::slot_type  b,
   input  logic               remaining,
   output logic               a_gt_b
);
   import tsp_pkg::*;

   logic [RT_W-1:0] key_a;
   logic [RT_W-1:0] key_b;

   // remaining time wraps at 16 bits
   assign key_a  = remaining ? RT_W'(a.runtime - a.progress) : a.runtime;
   assign key_b  = remaining ? RT_W'(b.runtime - b.progress) : b.runtime;
   assign a_gt_b = (key_a > key_b);

endmodule

// ===== hdl/tsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsp_ctrl
// Sequencer: arrivals, bubble-sort passes, round-robin remainder, run step.
// ----------------------------------------------------------------------------
module tsp_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_accept,
   input  logic                         req_cmd,
   input  logic [tsp_pkg::ID_W-1:0]     req_task_id,
   input  logic [tsp_pkg::RT_W-1:0]     req_runtime,
   input  logic [tsp_pkg::POL_W-1:0]    policy,
   input  logic [tsp_pkg::QUANT_W-1:0]  quantum,
   input  tsp_pkg::slot_type            head,
   input  logic                         rsp_free,
   output logic                         ready,
   output tsp_pkg::qctl_type            qctl,
   output logic                         rsp_load,
   output tsp_pkg::rsp_type             rsp
);
   import tsp_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      held_ff, held_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   slot_type              carry_ff, carry_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic                  swap_ff, swap_in;
   logic [QUANT_W-1:0]    rem_ff, rem_in;
   logic [TICK_IDX_W-1:0] bit_ff, bit_in;
   rsp_type               res_ff, res_in;

   logic                  key_gt;
   logic                  reorder_ok;
   logic [QUANT_W:0]      mod_t;
   logic [QUANT_W:0]      mod_q;
   logic [QUANT_W-1:0]    rem_next;
   logic [IDX_W-1:0]      tail_idx;
   logic [IDX_W-1:0]      pen_idx;
   logic [RT_W-1:0]       prog_next;

   tsp_keycmp u_keycmp (
      .a         (carry_ff),
      .b         (head),
      .remaining (policy == POL_SRTF),
      .a_gt_b    (key_gt)
   );

   assign reorder_ok = (held_ff >= CNT_W'(MIN_REORDER));

   // one restoring-remainder step per cycle, MSB of the tick first
   assign mod_q    = (quantum == '0) ? (QUANT_W + 1)'(1) : {1'b0, quantum};
   assign mod_t    = {rem_ff, tick_ff[bit_ff]};
   assign rem_next = (mod_t >= mod_q) ? QUANT_W'(mod_t - mod_q) : mod_t[QUANT_W-1:0];

   assign tail_idx = IDX_W'(held_ff - CNT_W'(1));
   assign pen_idx  = IDX_W'(held_ff - CNT_W'(2));

   assign prog_next = (head.progress == '1) ? head.progress : RT_W'(head.progress + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
         tick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         tick_ff  <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      step_ff  <= step_in;
      swap_ff  <= swap_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      res_ff   <= res_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_cmd == CMD_TICK) ? ST_PLAN : ST_REPLY;
            end
         end
         ST_PLAN: begin
            priority if (reorder_ok && (policy == POL_SJF || policy == POL_SRTF)) begin
               state_in = ST_SORT;
            end else if (reorder_ok && policy == POL_RR) begin
               state_in = ST_MOD;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_SORT: begin
            if (step_ff == held_ff) begin
               state_in = swap_ff ? ST_SORT : ST_RUN;
            end
         end
         ST_MOD: begin
            if (bit_ff == '0) begin
               state_in = (rem_next == '0) ? ST_ROT : ST_RUN;
            end
         end
         ST_ROT: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      held_in   = held_ff;
      tick_in   = tick_ff;
      carry_in  = carry_ff;
      step_in   = step_ff;
      swap_in   = swap_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      res_in    = res_ff;
      qctl.op   = Q_NONE;
      qctl.idx  = '0;
      qctl.data = head;
      ready     = 1'b0;
      rsp_load  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (req_accept) begin
               res_in = '0;
               unique case (req_cmd)
                  CMD_ARRIVE: begin
                     if (held_ff < CNT_W'(QUEUE_DEPTH)) begin
                        qctl.op            = Q_WR;
                        qctl.idx           = IDX_W'(held_ff);
                        qctl.data.task_id  = req_task_id;
                        qctl.data.runtime  = req_runtime;
                        qctl.data.progress = '0;
                        // a task arriving between ticks belongs to the next tick
                        qctl.data.arrival  = TICK_W'(tick_ff + 1'b1);
                        held_in            = CNT_W'(held_ff + 1'b1);
                        res_in.accepted    = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     tick_in = TICK_W'(tick_ff + 1'b1);
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         ST_PLAN: begin
            step_in = '0;
            swap_in = 1'b0;
            rem_in  = '0;
            bit_in  = TICK_IDX_W'(TICK_W - 1);
         end
         ST_SORT: begin
            // one bubble pass: head pops into carry, the larger of the two
            // goes to the tail; equal keys keep their order
            priority if (step_ff == '0) begin
               carry_in = head;
               swap_in  = 1'b0;
               qctl.op  = Q_SHIFT;
               step_in  = CNT_W'(step_ff + 1'b1);
            end else if (step_ff < held_ff) begin
               qctl.op  = Q_SHIFT_WR;
               qctl.idx = pen_idx;
               if (key_gt) begin
                  qctl.data = head;
                  swap_in   = 1'b1;
               end else begin
                  qctl.data = carry_ff;
                  carry_in  = head;
               end
               step_in = CNT_W'(step_ff + 1'b1);
            end else begin
               qctl.op   = Q_WR;
               qctl.idx  = tail_idx;
               qctl.data = carry_ff;
               step_in   = '0;
            end
         end
         ST_MOD: begin
            rem_in = rem_next;
            bit_in = TICK_IDX_W'(bit_ff - 1'b1);
         end
         ST_ROT: begin
            qctl.op   = Q_SHIFT_WR;
            qctl.idx  = tail_idx;
            qctl.data = head;
         end
         ST_RUN: begin
            if (held_ff != '0) begin
               res_in.ran_valid = 1'b1;
               res_in.ran_id    = head.task_id;
               if (prog_next >= head.runtime) begin
                  res_in.done_res   = 1'b1;
                  res_in.done_time  = tick_ff;
                  res_in.turnaround = TICK_W'(tick_ff - head.arrival);
                  qctl.op           = Q_SHIFT;
                  held_in           = CNT_W'(held_ff - 1'b1);
               end else begin
                  qctl.op            = Q_WR;
                  qctl.idx           = '0;
                  qctl.data.progress = prog_next;
               end
            end
         end
         ST_REPLY: begin
            rsp_load = rsp_free;
         end
         default: begin
            ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp             = res_ff;
      rsp.queue_count = held_ff;
   end

endmodule
